// ----- hw/rtl/eihc_pkg.sv -----
// eihc_pkg: types, codes and defaults shared by the header classifier files
// no dependencies; compiled first
`default_nettype none

package eihc_pkg;

    // default sizes
    localparam int HEADER_BYTES_DEF = 32;
    localparam int LENGTH_BITS_DEF  = 16;

    // the parse only ever looks at the first 32 bytes of a frame
    localparam int VIEW_BYTES = 32;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_FRAME_LENGTH = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0]  MIN_FRAME_LENGTH_RST = 16'd60;
    localparam logic [CFG_DATA_BITS-1:0]  MAX_FRAME_LENGTH_RST = 16'd1514;

    // ethertypes
    localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    // ip protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_FRAG = 8'd44;
    localparam logic [7:0] PROTO_ESP  = 8'd50;
    localparam logic [7:0] PROTO_AH   = 8'd51;

    // result codes
    localparam logic [1:0] L3_UNKNOWN = 2'd0;
    localparam logic [1:0] L3_IPV4    = 2'd1;
    localparam logic [1:0] L3_IPV6    = 2'd2;
    localparam logic [1:0] L3_ARP     = 2'd3;

    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_UDP  = 2'd1;
    localparam logic [1:0] L4_TCP  = 2'd2;
    localparam logic [1:0] L4_ICMP = 2'd3;

    localparam int FLAG_OPTIONS  = 0;
    localparam int FLAG_FRAGMENT = 1;
    localparam int FLAG_IPSEC    = 2;
    localparam int FLAG_IHL_ERR  = 3;

    localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
    localparam logic [7:0] IPV4_HDR_LEN = 8'd20;
    localparam logic [7:0] IPV6_HDR_LEN = 8'd40;

    // first 32 header bytes, zero where not received
    typedef logic [VIEW_BYTES-1:0][7:0] hdr_view_t;

    typedef struct packed {
        logic        length_error;
        logic        jumbo;
        logic        l2_valid;
        logic [1:0]  vlan_tags;
        logic [1:0]  l3_kind;
        logic [7:0]  l3_hdr_offset;
        logic [3:0]  ip_flags;
        logic [1:0]  l4_kind;
        logic [7:0]  l4_hdr_offset;
        logic [15:0] frame_size;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ethernet_ip_header_classifier.sv -----
// ethernet_ip_header_classifier: top level, frame byte input to one result per frame
// depends on eihc_pkg, eihc_store, eihc_parse
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   input     | in_valid / in_stall  | data_byte, last_byte
//   output    | out_valid / out_stall| length_error .. frame_size
//   config    | cfg_write            | cfg_index, cfg_data
//
// one byte a cycle unless in_stall holds the input; the last byte goes to the input register,
// then the result register loads it behind the store and parse logic
// reset clears the byte count, the valid bits and sets the length limits to defaults
// input stalls only while a finished result waits in the result register and the
// byte in the input register is a last byte
`default_nettype none

module ethernet_ip_header_classifier #(
    parameter int HEADER_BYTES = eihc_pkg::HEADER_BYTES_DEF,
    parameter int LENGTH_BITS  = eihc_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_write,
    input  wire logic [eihc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [eihc_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           data_byte,
    input  wire logic                                 last_byte,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      length_error,
    output logic                                      jumbo,
    output logic                                      l2_valid,
    output logic [1:0]                                vlan_tags,
    output logic [1:0]                                l3_kind,
    output logic [7:0]                                l3_hdr_offset,
    output logic [3:0]                                ip_flags,
    output logic [1:0]                                l4_kind,
    output logic [7:0]                                l4_hdr_offset,
    output logic [15:0]                               frame_size
);

    logic [eihc_pkg::CFG_DATA_BITS-1:0] min_len_reg;
    logic [eihc_pkg::CFG_DATA_BITS-1:0] max_len_reg;
    logic [LENGTH_BITS-1:0]             byte_count_reg;

    logic                               s1_valid_reg;
    logic [7:0]                         s1_data_reg;
    logic                               s1_last_reg;
    logic [LENGTH_BITS-1:0]             s1_idx_reg;
    logic [LENGTH_BITS-1:0]             s1_len_reg;

    logic                               out_valid_reg;
    eihc_pkg::result_t                  out_result_reg;

    logic                               out_free;
    logic                               s1_move;
    logic                               in_accept;
    eihc_pkg::hdr_view_t                view;
    eihc_pkg::result_t                  result;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= eihc_pkg::MIN_FRAME_LENGTH_RST;
            max_len_reg <= eihc_pkg::MAX_FRAME_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                eihc_pkg::CFG_MIN_FRAME_LENGTH: min_len_reg <= cfg_data;
                eihc_pkg::CFG_MAX_FRAME_LENGTH: max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // byte count saturates, and the stored length is the count after this byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (last_byte)
                begin
                    byte_count_reg <= '0;
                end
                else if (byte_count_reg != '1)
                begin
                    byte_count_reg <= byte_count_reg + 1'b1;
                end
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
            s1_idx_reg  <= byte_count_reg;
            s1_len_reg  <= (byte_count_reg == '1) ? byte_count_reg : byte_count_reg + 1'b1;
        end
    end

    eihc_store #(
        .HEADER_BYTES (HEADER_BYTES),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_idx  (s1_idx_reg),
        .wr_data (s1_data_reg),
        .rd_len  (s1_len_reg),
        .view    (view)
    );

    eihc_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .view        (view),
        .frame_bytes (s1_len_reg),
        .min_len     (min_len_reg),
        .max_len     (max_len_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_last_reg)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign length_error  = out_result_reg.length_error;
    assign jumbo         = out_result_reg.jumbo;
    assign l2_valid      = out_result_reg.l2_valid;
    assign vlan_tags     = out_result_reg.vlan_tags;
    assign l3_kind       = out_result_reg.l3_kind;
    assign l3_hdr_offset = out_result_reg.l3_hdr_offset;
    assign ip_flags      = out_result_reg.ip_flags;
    assign l4_kind       = out_result_reg.l4_kind;
    assign l4_hdr_offset = out_result_reg.l4_hdr_offset;
    assign frame_size    = out_result_reg.frame_size;

endmodule

`default_nettype wire

// ----- hw/rtl/eihc_store.sv -----
// eihc_store: header byte store with a forwarded view of the first 32 bytes
// depends on eihc_pkg
`default_nettype none

module eihc_store #(
    parameter int HEADER_BYTES = eihc_pkg::HEADER_BYTES_DEF,
    parameter int LENGTH_BITS  = eihc_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [LENGTH_BITS-1:0] wr_idx,
    input  wire logic [7:0]             wr_data,
    input  wire logic [LENGTH_BITS-1:0] rd_len,
    output eihc_pkg::hdr_view_t         view
);

    localparam int IDX_W = $clog2(HEADER_BYTES);

    logic [7:0] header_mem [HEADER_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx < LENGTH_BITS'(HEADER_BYTES)))
        begin
            header_mem[wr_idx[IDX_W-1:0]] <= wr_data;
        end
    end

    // the byte being written is forwarded, bytes past the frame read as zero
    always_comb
    begin
        for (int i = 0; i < eihc_pkg::VIEW_BYTES; i++)
        begin
            if (LENGTH_BITS'(i) >= rd_len)
            begin
                view[i] = 8'h00;
            end
            else if (wr_idx == LENGTH_BITS'(i))
            begin
                view[i] = wr_data;
            end
            else
            begin
                view[i] = header_mem[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/eihc_parse.sv -----
// eihc_parse: combinational classification of one frame from its header view
// depends on eihc_pkg
`default_nettype none

module eihc_parse #(
    parameter int LENGTH_BITS = eihc_pkg::LENGTH_BITS_DEF
) (
    input  wire eihc_pkg::hdr_view_t                   view,
    input  wire logic [LENGTH_BITS-1:0]                frame_bytes,
    input  wire logic [eihc_pkg::CFG_DATA_BITS-1:0]    min_len,
    input  wire logic [eihc_pkg::CFG_DATA_BITS-1:0]    max_len,
    output eihc_pkg::result_t                          result
);

    localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    // byte at offset k from the l3 header, for n tags in front of it
    function automatic logic [7:0] l3_byte(eihc_pkg::hdr_view_t v, logic [1:0] n, int k);
        logic [7:0] b;
        case (n)
            2'd0:    b = v[14 + k];
            2'd1:    b = v[18 + k];
            default: b = v[22 + k];
        endcase
        return b;
    endfunction

    logic [CMP_W-1:0] len_ext;
    logic             outer_tag;
    logic             inner_tag;
    logic [1:0]       n_tags;
    logic [15:0]      etype;
    logic [15:0]      frag;
    logic [7:0]       l3_first;
    logic [3:0]       ihl;
    logic [7:0]       proto;
    logic [7:0]       l3_off;
    logic [7:0]       hlen;
    logic [1:0]       l3_kind;
    logic [1:0]       l4_kind;
    logic [3:0]       flags;

    assign len_ext   = CMP_W'(frame_bytes);
    assign outer_tag = ({view[12], view[13]} == eihc_pkg::ETYPE_QINQ);
    assign inner_tag = outer_tag ? ({view[16], view[17]} == eihc_pkg::ETYPE_VLAN)
                                 : ({view[12], view[13]} == eihc_pkg::ETYPE_VLAN);
    assign n_tags    = {1'b0, outer_tag} + {1'b0, inner_tag};
    // ethertype sits two bytes ahead of the l3 header
    assign etype     = {l3_byte(view, n_tags, -2), l3_byte(view, n_tags, -1)};
    assign l3_off    = eihc_pkg::ETH_HDR_LEN + {4'd0, n_tags, 2'b00};
    assign l3_first  = l3_byte(view, n_tags, 0);
    assign ihl       = l3_first[3:0];
    assign frag      = {l3_byte(view, n_tags, 6), l3_byte(view, n_tags, 7)};

    always_comb
    begin
        l3_kind = eihc_pkg::L3_UNKNOWN;
        proto   = 8'd0;
        hlen    = 8'd0;
        flags   = 4'd0;
        if (etype == eihc_pkg::ETYPE_IPV4)
        begin
            l3_kind = eihc_pkg::L3_IPV4;
            if (ihl < 4'd5)
            begin
                flags[eihc_pkg::FLAG_IHL_ERR] = 1'b1;
            end
            else if (ihl > 4'd5)
            begin
                flags[eihc_pkg::FLAG_OPTIONS] = 1'b1;
            end
            else if ((frag & 16'h3FFF) != 16'd0)
            begin
                flags[eihc_pkg::FLAG_FRAGMENT] = 1'b1;
            end
            else if ((l3_byte(view, n_tags, 9) == eihc_pkg::PROTO_ESP) ||
                     (l3_byte(view, n_tags, 9) == eihc_pkg::PROTO_AH))
            begin
                flags[eihc_pkg::FLAG_IPSEC] = 1'b1;
            end
            else
            begin
                proto = l3_byte(view, n_tags, 9);
                hlen  = eihc_pkg::IPV4_HDR_LEN;
            end
        end
        else if (etype == eihc_pkg::ETYPE_IPV6)
        begin
            l3_kind = eihc_pkg::L3_IPV6;
            if ((l3_byte(view, n_tags, 6) == eihc_pkg::PROTO_ESP) ||
                (l3_byte(view, n_tags, 6) == eihc_pkg::PROTO_AH))
            begin
                flags[eihc_pkg::FLAG_OPTIONS] = 1'b1;
                flags[eihc_pkg::FLAG_IPSEC]   = 1'b1;
            end
            else if (l3_byte(view, n_tags, 6) == eihc_pkg::PROTO_FRAG)
            begin
                flags[eihc_pkg::FLAG_OPTIONS]  = 1'b1;
                flags[eihc_pkg::FLAG_FRAGMENT] = 1'b1;
            end
            else
            begin
                proto = l3_byte(view, n_tags, 6);
                hlen  = eihc_pkg::IPV6_HDR_LEN;
            end
        end
        else if (etype == eihc_pkg::ETYPE_ARP)
        begin
            l3_kind = eihc_pkg::L3_ARP;
        end

        case (proto)
            eihc_pkg::PROTO_UDP:  l4_kind = eihc_pkg::L4_UDP;
            eihc_pkg::PROTO_TCP:  l4_kind = eihc_pkg::L4_TCP;
            eihc_pkg::PROTO_ICMP: l4_kind = eihc_pkg::L4_ICMP;
            default:              l4_kind = eihc_pkg::L4_NONE;
        endcase
        // unknown next header on ipv6 counts as an extension
        if ((l4_kind == eihc_pkg::L4_NONE) && (l3_kind == eihc_pkg::L3_IPV6))
        begin
            flags[eihc_pkg::FLAG_OPTIONS] = 1'b1;
        end
    end

    always_comb
    begin
        result = '0;
        if (len_ext < CMP_W'(min_len))
        begin
            result.length_error = 1'b1;
        end
        else
        begin
            result.jumbo     = (len_ext > CMP_W'(max_len));
            result.l2_valid  = 1'b1;
            result.vlan_tags = {inner_tag, outer_tag};
            result.l3_kind   = l3_kind;
            result.ip_flags  = flags;
            result.l4_kind   = l4_kind;
            if ((l3_kind == eihc_pkg::L3_IPV4) || (l3_kind == eihc_pkg::L3_IPV6))
            begin
                result.l3_hdr_offset = l3_off;
            end
            if (l4_kind != eihc_pkg::L4_NONE)
            begin
                result.l4_hdr_offset = l3_off + hlen;
            end
            result.frame_size = (len_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the ethernet/vlan/ip header classifier
// depends on eihc_pkg and ethernet_ip_header_classifier; drives frames a byte at a time
// and checks every classification against a bit-accurate predictor held in a class

module tb_top;
    import eihc_pkg::*;

    localparam int unsigned COUNT_MAX   = (1 << LENGTH_BITS_DEF) - 1;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned PHASES      = 8;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    // ipv6 "no next header", any code outside the parsed set will do
    localparam logic [7:0] PROTO_NO_NEXT = 8'd59;

    typedef enum int
    {
        TAGS_NONE,
        TAGS_QINQ,
        TAGS_VLAN,
        TAGS_QINQ_VLAN,
        TAGS_VLAN_QINQ,
        TAGS_QINQ_QINQ
    } tag_mode_e;

    class classification_board;
        logic [7:0]  header_bytes[HEADER_BYTES_DEF];
        int unsigned byte_cnt = 0;
        logic [15:0] min_len = MIN_FRAME_LENGTH_RST;
        logic [15:0] max_len = MAX_FRAME_LENGTH_RST;
        result_t     expected_classes[$];
        int unsigned errors = 0;
        int unsigned results_seen = 0;

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx == CFG_MIN_FRAME_LENGTH)
                min_len = val;
            else if (idx == CFG_MAX_FRAME_LENGTH)
                max_len = val;
        endfunction

        function int unsigned pending();
            return expected_classes.size();
        endfunction

        // bytes past the end of the frame or the stored header read as zero
        function logic [7:0] hdr8(int unsigned idx, int unsigned flen);
            if (idx >= HEADER_BYTES_DEF || idx >= flen)
                return 8'h00;
            return header_bytes[idx];
        endfunction

        function logic [15:0] hdr16(int unsigned idx, int unsigned flen);
            return {hdr8(idx, flen), hdr8(idx + 1, flen)};
        endfunction

        function result_t classify_frame(int unsigned flen);
            result_t     r;
            logic [15:0] etype;
            logic [15:0] frag;
            logic [7:0]  proto;
            logic [3:0]  ihl;
            int unsigned pos;
            int unsigned hlen;
            r = '0;
            proto = '0;
            hlen = 0;
            if (flen < min_len)
            begin
                r.length_error = 1'b1;
                return r;
            end
            r.jumbo = (flen > max_len);
            r.l2_valid = 1'b1;
            r.frame_size = 16'(flen);
            pos = 12;
            etype = hdr16(pos, flen);
            if (etype == ETYPE_QINQ)
            begin
                r.vlan_tags[0] = 1'b1;
                pos += 4;
                etype = hdr16(pos, flen);
            end
            if (etype == ETYPE_VLAN)
            begin
                r.vlan_tags[1] = 1'b1;
                pos += 4;
                etype = hdr16(pos, flen);
            end
            if (etype == ETYPE_IPV4)
            begin
                r.l3_kind = L3_IPV4;
                r.l3_hdr_offset = 8'(pos + 2);
                ihl = 4'(hdr8(pos + 2, flen));
                frag = hdr16(pos + 8, flen);
                proto = hdr8(pos + 11, flen);
                if (ihl < 4'd5)
                begin
                    r.ip_flags[FLAG_IHL_ERR] = 1'b1;
                    proto = '0;
                end
                else if (ihl > 4'd5)
                begin
                    r.ip_flags[FLAG_OPTIONS] = 1'b1;
                    proto = '0;
                end
                else if (frag[13:0] != 14'd0)
                begin
                    r.ip_flags[FLAG_FRAGMENT] = 1'b1;
                    proto = '0;
                end
                else if (proto == PROTO_ESP || proto == PROTO_AH)
                begin
                    r.ip_flags[FLAG_IPSEC] = 1'b1;
                    proto = '0;
                end
                else
                    hlen = IPV4_HDR_LEN;
            end
            else if (etype == ETYPE_IPV6)
            begin
                r.l3_kind = L3_IPV6;
                r.l3_hdr_offset = 8'(pos + 2);
                proto = hdr8(pos + 8, flen);
                if (proto == PROTO_ESP || proto == PROTO_AH)
                begin
                    r.ip_flags[FLAG_OPTIONS] = 1'b1;
                    r.ip_flags[FLAG_IPSEC] = 1'b1;
                    proto = '0;
                end
                else if (proto == PROTO_FRAG)
                begin
                    r.ip_flags[FLAG_OPTIONS] = 1'b1;
                    r.ip_flags[FLAG_FRAGMENT] = 1'b1;
                    proto = '0;
                end
                else
                    hlen = IPV6_HDR_LEN;
            end
            else if (etype == ETYPE_ARP)
                r.l3_kind = L3_ARP;

            case (proto)
                PROTO_UDP:  r.l4_kind = L4_UDP;
                PROTO_TCP:  r.l4_kind = L4_TCP;
                PROTO_ICMP: r.l4_kind = L4_ICMP;
                default:
                    // an ipv6 next header we do not follow counts as an extension
                    if (r.l3_kind == L3_IPV6)
                        r.ip_flags[FLAG_OPTIONS] = 1'b1;
            endcase
            if (r.l4_kind != L4_NONE)
                r.l4_hdr_offset = r.l3_hdr_offset + 8'(hlen);
            return r;
        endfunction

        function void note_input(logic [7:0] b, logic is_last);
            if (byte_cnt < HEADER_BYTES_DEF)
                header_bytes[byte_cnt] = b;
            if (byte_cnt < COUNT_MAX)
                byte_cnt++;
            if (is_last)
            begin
                expected_classes.push_back(classify_frame(byte_cnt));
                byte_cnt = 0;
            end
        endfunction

        function void compare_field(string fname, int unsigned want, int unsigned got);
            if (want != got)
            begin
                if (errors < 10)
                    $display("result %0d: %s expected %0d, got %0d",
                             results_seen, fname, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_classes.size() == 0)
            begin
                if (errors < 10)
                    $display("classification with nothing pending, frame_size %0d",
                             got.frame_size);
                errors++;
                return;
            end
            want = expected_classes.pop_front();
            compare_field("length_error",  want.length_error,  got.length_error);
            compare_field("jumbo",         want.jumbo,         got.jumbo);
            compare_field("l2_valid",      want.l2_valid,      got.l2_valid);
            compare_field("vlan_tags",     want.vlan_tags,     got.vlan_tags);
            compare_field("l3_kind",       want.l3_kind,       got.l3_kind);
            compare_field("l3_hdr_offset", want.l3_hdr_offset, got.l3_hdr_offset);
            compare_field("ip_flags",      want.ip_flags,      got.ip_flags);
            compare_field("l4_kind",       want.l4_kind,       got.l4_kind);
            compare_field("l4_hdr_offset", want.l4_hdr_offset, got.l4_hdr_offset);
            compare_field("frame_size",    want.frame_size,    got.frame_size);
            results_seen++;
        endfunction

        function bit wrap_up();
            if (expected_classes.size() != 0)
            begin
                $display("%0d classifications never arrived", expected_classes.size());
                return 1'b0;
            end
            return errors == 0;
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [7:0]                data_byte = '0;
    logic                      last_byte = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      length_error;
    logic                      jumbo;
    logic                      l2_valid;
    logic [1:0]                vlan_tags;
    logic [1:0]                l3_kind;
    logic [7:0]                l3_hdr_offset;
    logic [3:0]                ip_flags;
    logic [1:0]                l4_kind;
    logic [7:0]                l4_hdr_offset;
    logic [15:0]               frame_size;

    classification_board cls_chk = new;
    bit                  quiet = 1'b0;
    int unsigned         stall_left = 0;
    int unsigned         cycle_count = 0;

    ethernet_ip_header_classifier i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .length_error  (length_error),
        .jumbo         (jumbo),
        .l2_valid      (l2_valid),
        .vlan_tags     (vlan_tags),
        .l3_kind       (l3_kind),
        .l3_hdr_offset (l3_hdr_offset),
        .ip_flags      (ip_flags),
        .l4_kind       (l4_kind),
        .l4_hdr_offset (l4_hdr_offset),
        .frame_size    (frame_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver back-pressure in bursts of random length
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            cls_chk.check_result({length_error, jumbo, l2_valid, vlan_tags, l3_kind,
                                  l3_hdr_offset, ip_flags, l4_kind, l4_hdr_offset,
                                  frame_size});
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cls_chk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cls_chk.set_reg(idx, val);
    endtask

    // only while idle: every classification back and the pipeline empty
    task automatic program_limits(input logic [15:0] lo, input logic [15:0] hi,
                                  input bit with_spare);
        drain_results();
        repeat (3) @(posedge clk);
        put_reg(CFG_MIN_FRAME_LENGTH, lo);
        put_reg(CFG_MAX_FRAME_LENGTH, hi);
        if (with_spare)
        begin
            put_reg(CFG_SPARE_A, 16'($urandom));
            put_reg(CFG_SPARE_B, 16'($urandom));
        end
        cfg_write <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic is_last);
        if (!quiet && $urandom_range(0, 299) == 0)
            drain_results();
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cls_chk.note_input(b, is_last);
    endtask

    // builds the header with the given key fields and random filler, then sends len bytes
    task automatic send_frame(input tag_mode_e tm, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [15:0] frag,
                              input logic [7:0] proto, input int unsigned len);
        logic [7:0]  head[$];
        logic [31:0] tag_pair;
        int unsigned ntags;
        int unsigned base;
        int unsigned k;
        head = {};
        repeat (12) head.push_back(8'($urandom));
        case (tm)
            TAGS_QINQ:      tag_pair = {ETYPE_QINQ, 16'h0000};
            TAGS_VLAN:      tag_pair = {ETYPE_VLAN, 16'h0000};
            TAGS_QINQ_VLAN: tag_pair = {ETYPE_QINQ, ETYPE_VLAN};
            TAGS_VLAN_QINQ: tag_pair = {ETYPE_VLAN, ETYPE_QINQ};
            TAGS_QINQ_QINQ: tag_pair = {ETYPE_QINQ, ETYPE_QINQ};
            default:        tag_pair = '0;
        endcase
        ntags = (tm == TAGS_NONE) ? 0 : (tm == TAGS_QINQ || tm == TAGS_VLAN) ? 1 : 2;
        for (k = 0; k < ntags; k++)
        begin
            head.push_back(tag_pair[31:24]);
            head.push_back(tag_pair[23:16]);
            head.push_back(8'($urandom));
            head.push_back(8'($urandom));
            tag_pair = tag_pair << 16;
        end
        head.push_back(etype[15:8]);
        head.push_back(etype[7:0]);
        base = head.size();
        repeat (40) head.push_back(8'($urandom));
        if (etype == ETYPE_IPV4)
        begin
            head[base] = {4'h4, ihl};
            head[base + 6] = frag[15:8];
            head[base + 7] = frag[7:0];
            head[base + 9] = proto;
        end
        else if (etype == ETYPE_IPV6)
        begin
            head[base] = {4'h6, 4'($urandom)};
            head[base + 6] = proto;
        end
        for (k = 0; k < len; k++)
            push_byte((k < head.size()) ? head[k] : 8'($urandom), k == len - 1);
    endtask

    task automatic random_frame(output int unsigned len);
        tag_mode_e   tm;
        logic [15:0] etype;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        tm = tag_mode_e'($urandom_range(0, 5));
        case ($urandom_range(0, 8))
            0, 1, 2, 3: etype = ETYPE_IPV4;
            4, 5, 6:    etype = ETYPE_IPV6;
            7:          etype = ETYPE_ARP;
            default:    etype = 16'($urandom);
        endcase
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        frag = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {2'($urandom), 14'd0};
        case ($urandom_range(0, 9))
            0, 1, 2: proto = PROTO_UDP;
            3, 4:    proto = PROTO_TCP;
            5:       proto = PROTO_ICMP;
            6:       proto = PROTO_FRAG;
            7:       proto = PROTO_ESP;
            8:       proto = PROTO_AH;
            default: proto = 8'($urandom);
        endcase
        // mostly the whole parsed header arrives; some frames are cut short inside it
        case ($urandom_range(0, 7))
            0, 1:    len = $urandom_range(1, 40);
            7:       len = $urandom_range(65, 200);
            default: len = $urandom_range(32, 64);
        endcase
        send_frame(tm, etype, ihl, frag, proto, len);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned frames;
        int unsigned nbytes;
        int unsigned len;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limits straight out of reset: exactly minimum and one short
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_UDP, MIN_FRAME_LENGTH_RST);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_UDP,
                   MIN_FRAME_LENGTH_RST - 1);

        program_limits(16'h0000, 16'hFFFF, 1'b1);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_UDP, 1);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_TCP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_ICMP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd4, 16'h0000, PROTO_UDP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd6, 16'h0000, PROTO_UDP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h2000, PROTO_UDP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0001, PROTO_UDP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h4000, PROTO_UDP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_ESP, 32);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_AH, 32);
        send_frame(TAGS_VLAN, ETYPE_IPV6, 4'd5, 16'h0000, PROTO_UDP, 40);
        send_frame(TAGS_NONE, ETYPE_IPV6, 4'd5, 16'h0000, PROTO_ESP, 40);
        send_frame(TAGS_NONE, ETYPE_IPV6, 4'd5, 16'h0000, PROTO_AH, 40);
        send_frame(TAGS_NONE, ETYPE_IPV6, 4'd5, 16'h0000, PROTO_FRAG, 40);
        send_frame(TAGS_NONE, ETYPE_IPV6, 4'd5, 16'h0000, PROTO_NO_NEXT, 40);
        send_frame(TAGS_QINQ, ETYPE_IPV6, 4'd5, 16'h0000, PROTO_TCP, 40);
        send_frame(TAGS_QINQ_VLAN, ETYPE_ARP, 4'd5, 16'h0000, PROTO_UDP, 32);
        send_frame(TAGS_QINQ_VLAN, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_TCP, 32);
        // outer tag after the inner one is not recognised
        send_frame(TAGS_VLAN_QINQ, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_TCP, 32);
        // cut off before the protocol byte: missing bytes read as zero
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_UDP, 20);

        // a short frame at the largest minimum
        quiet = 1'b1;
        program_limits(16'hFFFF, 16'hFFFE, 1'b0);
        send_frame(TAGS_NONE, ETYPE_IPV4, 4'd5, 16'h0000, PROTO_UDP, 10);
        quiet = 1'b0;

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       program_limits(16'h0000, 16'hFFFF, 1'b0);
                1:       program_limits(16'h0000, 16'h0000, 1'b1);
                2:       program_limits(MIN_FRAME_LENGTH_RST, MAX_FRAME_LENGTH_RST, 1'b0);
                3:       program_limits(16'hFFFF, 16'hFFFF, 1'b0);
                default: program_limits(16'($urandom_range(0, 48)),
                                        16'($urandom_range(0, 120)), 1'($urandom));
            endcase
            quiet = (phase == PHASES - 1) || ($urandom_range(0, 3) == 0);
            frames = 0;
            nbytes = 0;
            while (nbytes < 40 || frames < 1)
            begin
                random_frame(len);
                nbytes += len;
                frames++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (cls_chk.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (cls_chk.wrap_up())
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
